// ===== design/tds_pkg.sv =====
package tds_pkg;

    // Default ring depth in bytes; must be a power of two.
    localparam int unsigned BUFFER_DEPTH_DEFAULT = 256;

    // Action codes carried by an input transaction.
    localparam logic [1:0] ACT_WRITE  = 2'd0;
    localparam logic [1:0] ACT_FINISH = 2'd1;
    localparam logic [1:0] ACT_FETCH  = 2'd2;

    // Result fields produced by the ring controller.
    typedef struct packed {
        logic        frame_accepted;
        logic        segment_valid;
        logic [7:0]  segment_start;
        logic [8:0]  segment_length;
        logic [31:0] dropped_total;
    } result_t;

endpackage

// ===== design/tds_in_if.sv =====
interface tds_in_if;

    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [7:0]  data;
    logic        first_of_frame;
    logic [15:0] frame_length;
    logic [7:0]  fetch_index;

    modport source (
        output valid, action, data, first_of_frame, frame_length, fetch_index,
        input  ready
    );

    modport sink (
        input  valid, action, data, first_of_frame, frame_length, fetch_index,
        output ready
    );

endinterface

// ===== design/tds_out_if.sv =====
interface tds_out_if;

    logic        valid;
    logic        ready;
    logic        frame_accepted;
    logic        segment_valid;
    logic [7:0]  segment_start;
    logic [8:0]  segment_length;
    logic [7:0]  fetched_byte;
    logic [31:0] dropped_total;

    modport source (
        output valid, frame_accepted, segment_valid, segment_start, segment_length,
               fetched_byte, dropped_total,
        input  ready
    );

    modport sink (
        input  valid, frame_accepted, segment_valid, segment_start, segment_length,
               fetched_byte, dropped_total,
        output ready
    );

endinterface

// ===== design/tx_ring_dma_segmenter.sv =====
// Transmit ring that admits whole frames or nothing and hands contiguous
// segments to a DMA engine. Frame bytes, segment-finished events and unused
// actions may arrive back to back while results are taken; a fetch of a
// stored byte passes through the registered read port of the byte RAM and
// holds off new transactions. Every input transaction yields exactly one
// result transaction, which appears in the output register the cycle after
// acceptance (the cycle after the RAM read for a fetch) and waits there until
// taken. The ring starts empty after reset with no clearing pass; a fetch of a
// location never written returns an unspecified byte.
module tx_ring_dma_segmenter #(
    parameter int unsigned BUFFER_DEPTH = tds_pkg::BUFFER_DEPTH_DEFAULT
) (
    input  logic      clk,
    input  logic      rst_n,
    tds_in_if.sink    item,
    tds_out_if.source result
);

    localparam int unsigned AW = $clog2(BUFFER_DEPTH);

    typedef enum logic {
        S_IDLE,
        S_FETCH
    } state_t;

    state_t           state_reg;
    logic             out_valid_reg;
    tds_pkg::result_t out_res_reg;
    logic [7:0]       out_byte_reg;

    logic             accept;
    logic             is_fetch;
    logic             store_en;
    logic [AW-1:0]    store_addr;
    logic [7:0]       rd_data;
    tds_pkg::result_t ctrl_res;

    // A new transaction is taken when no fetch is in flight and the output
    // register is empty or being emptied.
    assign item.ready = (state_reg == S_IDLE) && (!out_valid_reg || result.ready);
    assign accept     = item.valid && item.ready;
    assign is_fetch   = (item.action == tds_pkg::ACT_FETCH);

    tds_ctrl #(
        .BUFFER_DEPTH (BUFFER_DEPTH)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .action         (item.action),
        .first_of_frame (item.first_of_frame),
        .frame_length   (item.frame_length),
        .store_en       (store_en),
        .store_addr     (store_addr),
        .res            (ctrl_res)
    );

    tds_ram #(
        .WIDTH (8),
        .DEPTH (BUFFER_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (store_en),
        .waddr (store_addr),
        .wdata (item.data),
        .re    (accept && is_fetch),
        .raddr (AW'(item.fetch_index)),
        .rdata (rd_data)
    );

    // Sequencer and output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
            out_res_reg   <= '0;
            out_byte_reg  <= 8'd0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        out_res_reg  <= ctrl_res;
                        out_byte_reg <= 8'd0;
                        if (is_fetch)
                        begin
                            out_valid_reg <= 1'b0;
                            state_reg     <= S_FETCH;
                        end
                        else
                        begin
                            out_valid_reg <= 1'b1;
                        end
                    end
                    else if (result.ready)
                    begin
                        out_valid_reg <= 1'b0;
                    end
                end
                S_FETCH:
                begin
                    out_byte_reg  <= rd_data;
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.frame_accepted = out_res_reg.frame_accepted;
    assign result.segment_valid  = out_res_reg.segment_valid;
    assign result.segment_start  = out_res_reg.segment_start;
    assign result.segment_length = out_res_reg.segment_length;
    assign result.fetched_byte   = out_byte_reg;
    assign result.dropped_total  = out_res_reg.dropped_total;

    // While a fetch is in flight the output register is empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_FETCH) |-> !out_valid_reg)
        else $error("output register occupied during a fetch");

    // A fetch result is presented once the registered RAM read has passed through the fetch state.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_fetch) |=> ##1 out_valid_reg)
        else $error("fetch result not presented after the RAM read");

    // A fetch never stores a byte or issues a segment.
    assert property (@(posedge clk) disable iff (!rst_n)
        (accept && is_fetch) |-> (!store_en && !ctrl_res.segment_valid))
        else $error("fetch changed the ring contents or the engine");

endmodule

// ===== design/tds_ram.sv =====
module tds_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/tds_ctrl.sv =====
module tds_ctrl #(
    parameter int unsigned BUFFER_DEPTH = tds_pkg::BUFFER_DEPTH_DEFAULT
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            accept,
    input  logic [1:0]                      action,
    input  logic                            first_of_frame,
    input  logic [15:0]                     frame_length,
    output logic                            store_en,
    output logic [$clog2(BUFFER_DEPTH)-1:0] store_addr,
    output tds_pkg::result_t                res
);

    localparam int unsigned AW = $clog2(BUFFER_DEPTH);
    localparam int unsigned PW = AW + 1;
    localparam logic [16:0] DEPTH_W = 17'(BUFFER_DEPTH);
    localparam logic [PW-1:0] DEPTH_P = PW'(BUFFER_DEPTH);

    logic [PW-1:0] head_reg, head_next;
    logic [PW-1:0] tail_reg, tail_next;
    logic          busy_reg, busy_next;
    logic [PW-1:0] active_len_reg, active_len_next;
    logic [31:0]   drop_reg, drop_next;
    logic [15:0]   left_reg, left_next;
    logic          admitted_reg, admitted_next;

    logic [PW-1:0] pend_now;
    logic [16:0]   free_now;
    logic [PW-1:0] pend_after;
    logic [AW-1:0] seg_start;
    logic [PW-1:0] seg_room;
    logic [PW-1:0] seg_len;
    logic          issue_req;
    logic          busy_mid;
    logic          accepted;

    // Next state of the ring, frame tracking and segment engine.
    always_comb
    begin
        head_next       = head_reg;
        tail_next       = tail_reg;
        busy_mid        = busy_reg;
        active_len_next = active_len_reg;
        drop_next       = drop_reg;
        left_next       = left_reg;
        admitted_next   = admitted_reg;
        issue_req       = 1'b0;
        accepted        = 1'b0;
        store_en        = 1'b0;

        pend_now = head_reg - tail_reg;
        free_now = DEPTH_W - 17'(pend_now);

        if (accept)
        begin
            case (action)
                tds_pkg::ACT_WRITE:
                begin
                    if (first_of_frame)
                    begin
                        if (frame_length == 16'd0)
                        begin
                            admitted_next = 1'b0;
                            left_next     = 16'd0;
                        end
                        else if ({1'b0, frame_length} > free_now)
                        begin
                            drop_next     = drop_reg + 32'(frame_length);
                            admitted_next = 1'b0;
                            left_next     = frame_length - 16'd1;
                        end
                        else
                        begin
                            admitted_next = 1'b1;
                            left_next     = frame_length - 16'd1;
                            store_en      = 1'b1;
                            accepted      = 1'b1;
                            issue_req     = (frame_length == 16'd1);
                        end
                    end
                    else if (left_reg != 16'd0)
                    begin
                        left_next = left_reg - 16'd1;
                        if (admitted_reg)
                        begin
                            store_en  = 1'b1;
                            accepted  = 1'b1;
                            issue_req = (left_reg == 16'd1);
                        end
                    end
                end
                tds_pkg::ACT_FINISH:
                begin
                    // Retire the active segment and try to issue the next one.
                    tail_next       = tail_reg + active_len_reg;
                    active_len_next = '0;
                    busy_mid        = 1'b0;
                    issue_req       = 1'b1;
                end
                default:
                begin
                end
            endcase
        end

        if (store_en)
        begin
            head_next = head_reg + PW'(1);
        end

        // Segment runs from the tail to the pending end or the physical end.
        pend_after = head_next - tail_next;
        seg_start  = tail_next[AW-1:0];
        seg_room   = DEPTH_P - {1'b0, seg_start};
        seg_len    = (seg_room > pend_after) ? pend_after : seg_room;

        busy_next = busy_mid;
        res.segment_valid  = 1'b0;
        res.segment_start  = 8'd0;
        res.segment_length = 9'd0;
        if (issue_req && !busy_mid && (pend_after != '0))
        begin
            busy_next          = 1'b1;
            active_len_next    = seg_len;
            res.segment_valid  = 1'b1;
            res.segment_start  = 8'(32'(seg_start));
            res.segment_length = 9'(32'(seg_len));
        end

        res.frame_accepted = accepted;
        res.dropped_total  = drop_next;
        store_addr         = head_reg[AW-1:0];
    end

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg       <= '0;
            tail_reg       <= '0;
            busy_reg       <= 1'b0;
            active_len_reg <= '0;
            drop_reg       <= 32'd0;
            left_reg       <= 16'd0;
            admitted_reg   <= 1'b0;
        end
        else
        begin
            head_reg       <= head_next;
            tail_reg       <= tail_next;
            busy_reg       <= busy_next;
            active_len_reg <= active_len_next;
            drop_reg       <= drop_next;
            left_reg       <= left_next;
            admitted_reg   <= admitted_next;
        end
    end

    // The ring never holds more bytes than its depth.
    assert property (@(posedge clk) disable iff (!rst_n)
        (head_reg - tail_reg) <= DEPTH_P)
        else $error("ring occupancy exceeds its depth");

    // An idle engine has no active segment; a busy one has a non-empty one.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg == (active_len_reg != '0))
        else $error("engine state and active segment length disagree");

    // An active segment never runs past the physical end of the ring.
    assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> ({1'b0, tail_reg[AW-1:0]} + active_len_reg) <= DEPTH_P)
        else $error("active segment wraps the ring");

endmodule
